FILE: hw/rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement core.
// No dependencies; design files use scoped names into it, test files import it.
package lrupr_pkg;

    localparam int MAX_WAYS_DEF  = 32;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 6;
    localparam int POS_W         = 5;
    localparam int FAULT_W       = 32;
    localparam int CTL_W         = 9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_FILL  = 2'd1,
        ST_FAULT = 2'd2
    } status_t;

    typedef struct packed {
        logic             update;
        logic             trunc;
        logic [CTL_W-1:0] depth;
        logic [CTL_W-1:0] lim;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/lrupr_ifs.sv
// Valid/ready channel interfaces for page requests and replacement results.
// Depends on lrupr_pkg for default widths.
interface lrupr_page_if #(
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_result_if #(
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [lrupr_pkg::POS_W-1:0]   position;
    logic [PAGE_BITS-1:0]          evicted_page;
    logic                          evicted_valid;
    logic [lrupr_pkg::FAULT_W-1:0] fault_count;

    modport source (output valid, output status, output position, output evicted_page,
                    output evicted_valid, output fault_count, input ready);
    modport sink   (input valid, input status, input position, input evicted_page,
                    input evicted_valid, input fault_count, output ready);
endinterface

FILE: hw/rtl/lrupr_cell.sv
// One recency slot: holds a page and its valid bit, compares against the key,
// and takes its neighbor's contents when the stack shifts. Depends on lrupr_pkg.
module lrupr_cell #(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrupr_pkg::cell_ctl_t ctl,
    input  logic [PAGE_BITS-1:0] key,
    input  logic [PAGE_BITS-1:0] prev_page,
    input  logic                 prev_valid,
    output logic [PAGE_BITS-1:0] page_q,
    output logic                 valid_q,
    output logic                 match
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 shift_in;
    logic                 drop;

    assign shift_in = ctl.update && (lrupr_pkg::CTL_W'(IDX) <= ctl.depth);
    assign drop     = ctl.trunc && (lrupr_pkg::CTL_W'(IDX) >= ctl.lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (drop)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_in)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_in)
        begin
            page_reg <= prev_page;
        end
    end

    assign page_q  = page_reg;
    assign valid_q = valid_reg;
    assign match   = valid_reg && (page_reg == key);

endmodule

FILE: hw/rtl/lrupr_chain.sv
// Row of recency cells, most recent first, with the victim read-out.
// Depends on lrupr_pkg and lrupr_cell.
module lrupr_chain #(
    parameter int MAX_WAYS  = lrupr_pkg::MAX_WAYS_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    localparam int IW       = $clog2(MAX_WAYS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrupr_pkg::cell_ctl_t ctl,
    input  logic [PAGE_BITS-1:0] key,
    input  logic [IW-1:0]        evict_idx,
    output logic [MAX_WAYS-1:0]  match_vec,
    output logic [PAGE_BITS-1:0] evict_page
);

    logic [PAGE_BITS-1:0] page_q  [MAX_WAYS];
    logic [MAX_WAYS-1:0]  valid_q;

    for (genvar i = 0; i < MAX_WAYS; i++)
    begin : g_cell
        logic [PAGE_BITS-1:0] prev_page;
        logic                 prev_valid;

        if (i == 0)
        begin : g_top
            assign prev_page  = key;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_link
            assign prev_page  = page_q[i-1];
            assign prev_valid = valid_q[i-1];
        end

        lrupr_cell #(
            .IDX       (i),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key        (key),
            .prev_page  (prev_page),
            .prev_valid (prev_valid),
            .page_q     (page_q[i]),
            .valid_q    (valid_q[i]),
            .match      (match_vec[i])
        );
    end

    always_comb
    begin
        evict_page = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (IW'(i) == evict_idx)
            begin
                evict_page = evict_page | page_q[i];
            end
        end
    end

endmodule

FILE: hw/rtl/lru_page_replacement_core.sv
// LRU page replacement core: top level with access sequencing and result register.
// Depends on lrupr_pkg, lrupr_ifs and lrupr_chain.
//
// Each access passes through accept, lookup (every cell compares the page at once,
// the match is encoded and registered) and update (the stack shifts and the result
// is registered). The update waits while the result register holds a result not
// yet taken, so the next page is accepted only after the last one's update. A
// waiting result does not block the next page's accept and lookup. Configuration
// writes take effect at once.
module lru_page_replacement_core #(
    parameter int MAX_WAYS  = lrupr_pkg::MAX_WAYS_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lrupr_page_if.sink                  req,
    lrupr_result_if.source              rsp,
    input  logic                        cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int IW = $clog2(MAX_WAYS);
    localparam int CW = $clog2(MAX_WAYS + 1);

    function automatic logic [CW-1:0] clamp_ways(input logic [lrupr_pkg::CFG_W-1:0] s);
        logic [lrupr_pkg::CTL_W-1:0] w;
        w = lrupr_pkg::CTL_W'(s);
        if (w == '0)
        begin
            w = lrupr_pkg::CTL_W'(1);
        end
        else if (w > lrupr_pkg::CTL_W'(MAX_WAYS))
        begin
            w = lrupr_pkg::CTL_W'(MAX_WAYS);
        end
        return CW'(w);
    endfunction

    lrupr_pkg::state_t            state_reg;
    lrupr_pkg::state_t            state_next;
    logic [lrupr_pkg::CFG_W-1:0]  set_size_reg;
    logic [CW-1:0]                occ_reg;
    logic [lrupr_pkg::FAULT_W-1:0] fault_total_reg;
    logic [lrupr_pkg::FAULT_W-1:0] fault_total_next;
    logic [PAGE_BITS-1:0]         key_reg;
    logic                         hit_reg;
    logic [IW-1:0]                hit_pos_reg;
    logic [PAGE_BITS-1:0]         evict_page_reg;

    logic                         out_valid_reg;
    lrupr_pkg::status_t           out_status_reg;
    logic [lrupr_pkg::POS_W-1:0]  out_pos_reg;
    logic [PAGE_BITS-1:0]         out_evict_reg;
    logic                         out_evict_valid_reg;
    logic [lrupr_pkg::FAULT_W-1:0] out_fault_reg;

    logic [CW-1:0]                lim;
    logic [CW-1:0]                cfg_lim;
    logic [MAX_WAYS-1:0]          match_vec;
    logic [PAGE_BITS-1:0]         evict_page;
    logic [IW-1:0]                hit_pos;
    logic                         update_go;
    logic                         is_fill;
    lrupr_pkg::status_t           status_now;
    lrupr_pkg::cell_ctl_t         ctl;

    assign lim     = clamp_ways(set_size_reg);
    assign cfg_lim = clamp_ways(cfg_wdata);
    assign is_fill = occ_reg < lim;

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (match_vec[i])
            begin
                hit_pos = hit_pos | IW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrupr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        update_go  = 1'b0;
        req.ready  = 1'b0;
        case (state_reg)
            lrupr_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = lrupr_pkg::S_LOOKUP;
                end
            end
            lrupr_pkg::S_LOOKUP:
            begin
                state_next = lrupr_pkg::S_UPDATE;
            end
            lrupr_pkg::S_UPDATE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    update_go  = 1'b1;
                    state_next = lrupr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lrupr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fault_total_next = fault_total_reg;
        ctl.update       = update_go;
        ctl.trunc        = cfg_we;
        ctl.lim          = lrupr_pkg::CTL_W'(cfg_lim);
        if (hit_reg)
        begin
            status_now = lrupr_pkg::ST_HIT;
            ctl.depth  = lrupr_pkg::CTL_W'(hit_pos_reg);
        end
        else if (is_fill)
        begin
            status_now = lrupr_pkg::ST_FILL;
            ctl.depth  = lrupr_pkg::CTL_W'(occ_reg);
        end
        else
        begin
            status_now = lrupr_pkg::ST_FAULT;
            ctl.depth  = lrupr_pkg::CTL_W'(occ_reg - CW'(1));
            if (fault_total_reg != '1)
            begin
                fault_total_next = fault_total_reg + lrupr_pkg::FAULT_W'(1);
            end
        end
    end

    lrupr_chain #(
        .MAX_WAYS  (MAX_WAYS),
        .PAGE_BITS (PAGE_BITS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (key_reg),
        .evict_idx  (IW'(occ_reg - CW'(1))),
        .match_vec  (match_vec),
        .evict_page (evict_page)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg    <= lrupr_pkg::CFG_W'(32);
            occ_reg         <= '0;
            fault_total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                set_size_reg <= cfg_wdata;
                if (occ_reg > cfg_lim)
                begin
                    occ_reg <= cfg_lim;
                end
            end
            else if (update_go && !hit_reg && is_fill)
            begin
                occ_reg <= occ_reg + CW'(1);
            end
            if (update_go)
            begin
                fault_total_reg <= fault_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            key_reg <= req.page;
        end
        if (state_reg == lrupr_pkg::S_LOOKUP)
        begin
            hit_reg        <= |match_vec;
            hit_pos_reg    <= hit_pos;
            evict_page_reg <= evict_page;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (update_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update_go)
        begin
            out_status_reg      <= status_now;
            out_pos_reg         <= hit_reg ? lrupr_pkg::POS_W'(hit_pos_reg) : '0;
            out_evict_reg       <= (status_now == lrupr_pkg::ST_FAULT) ? evict_page_reg : '0;
            out_evict_valid_reg <= (status_now == lrupr_pkg::ST_FAULT);
            out_fault_reg       <= fault_total_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.position      = out_pos_reg;
    assign rsp.evicted_page  = out_evict_reg;
    assign rsp.evicted_valid = out_evict_valid_reg;
    assign rsp.fault_count   = out_fault_reg;

    a_occ_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= lim)
        else $error("occupancy above set size");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrupr_pkg::S_LOOKUP) |-> $onehot0(match_vec))
        else $error("page held in more than one slot");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fault_total_reg >= $past(fault_total_reg))
        else $error("fault counter went backward");

    a_fill_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (update_go && !hit_reg && is_fill) |=> (occ_reg == $past(occ_reg) + CW'(1)))
        else $error("fill did not grow occupancy");

endmodule

FILE: test/lrupr_replacement_checker.sv
`timescale 1ns / 1ps
// Checker for the LRU page replacement core: watches the page, result and set_size
// write ports, predicts every access outcome and compares it field by field.
// Depends on lrupr_pkg and the lrupr_page_if / lrupr_result_if interfaces.
module lrupr_replacement_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    lrupr_page_if                       req,
    lrupr_result_if                     rsp,
    input  logic                        cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
    output int                          mismatches,
    output int                          outstanding,
    output int                          hits,
    output int                          fills,
    output int                          faults
);
    import lrupr_pkg::*;

    localparam int WAYS = MAX_WAYS_DEF;
    localparam int PW   = PAGE_BITS_DEF;

    typedef struct {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [PW-1:0]      evicted_page;
        logic               evicted_valid;
        logic [FAULT_W-1:0] fault_count;
    } outcome_t;

    logic [PW-1:0]      lru_stack [WAYS];
    int                 resident;
    logic [FAULT_W-1:0] fault_tally;
    logic [CFG_W-1:0]   set_size_q;
    outcome_t           awaited_outcomes [$];

    function automatic int active_ways();
        if (set_size_q == '0)
            return 1;
        if (set_size_q > WAYS)
            return WAYS;
        return int'(set_size_q);
    endfunction

    function automatic void push_top(input int depth, input logic [PW-1:0] pg);
        for (int k = depth; k > 0; k--)
            lru_stack[k] = lru_stack[k-1];
        lru_stack[0] = pg;
    endfunction

    function automatic outcome_t lru_access(input logic [PW-1:0] pg);
        outcome_t o;
        int       hit_at;
        hit_at          = -1;
        o.status        = ST_HIT;
        o.position      = '0;
        o.evicted_page  = '0;
        o.evicted_valid = 1'b0;
        for (int i = 0; i < resident; i++)
            if (hit_at < 0 && lru_stack[i] == pg)
                hit_at = i;
        if (hit_at >= 0)
        begin
            o.position = POS_W'(hit_at);
            push_top(hit_at, pg);
        end
        else if (resident < active_ways())
        begin
            o.status = ST_FILL;
            push_top(resident, pg);
            resident++;
        end
        else
        begin
            o.status        = ST_FAULT;
            o.evicted_page  = lru_stack[resident-1];
            o.evicted_valid = 1'b1;
            push_top(resident - 1, pg);
            if (fault_tally != '1)
                fault_tally++;
        end
        o.fault_count = fault_tally;
        return o;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t next;
        int       lim;
        if (!rst_n)
        begin
            awaited_outcomes.delete();
            resident    = 0;
            fault_tally = '0;
            set_size_q  = CFG_W'(WAYS);
            mismatches  = 0;
            outstanding = 0;
            hits        = 0;
            fills       = 0;
            faults      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no access pending: expected none, actual status %0d",
                             $time, rsp.status);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    compare_field("status", 32'(want.status), 32'(rsp.status));
                    compare_field("position", 32'(want.position), 32'(rsp.position));
                    compare_field("evicted_page", 32'(want.evicted_page),
                                  32'(rsp.evicted_page));
                    compare_field("evicted_valid", 32'(want.evicted_valid),
                                  32'(rsp.evicted_valid));
                    compare_field("fault_count", want.fault_count, rsp.fault_count);
                end
            end
            if (cfg_we)
            begin
                set_size_q = cfg_wdata;
                lim        = active_ways();
                if (resident > lim)
                    resident = lim;
            end
            if (req.valid && req.ready)
            begin
                next = lru_access(req.page);
                awaited_outcomes.push_back(next);
                case (next.status)
                    ST_HIT:  hits++;
                    ST_FILL: fills++;
                    default: faults++;
                endcase
            end
            outstanding = awaited_outcomes.size();
        end
    end

endmodule

FILE: test/tb_lru_page_replacement_core.sv
`timescale 1ns / 1ps
// Testbench top for the LRU page replacement core: clock, reset, page and result
// traffic with random gaps and stalls, set_size writes, and the verdict.
// Depends on lrupr_pkg, lrupr_ifs, lru_page_replacement_core and lrupr_replacement_checker.
module tb_lru_page_replacement_core;
    import lrupr_pkg::*;

    localparam int PHASES    = 11;
    localparam int PHASE_LEN = 120;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               mismatches;
    int               outstanding;
    int               hits;
    int               fills;
    int               faults;
    int               cfg_writes;
    bit               no_idle;

    lrupr_page_if   req_if ();
    lrupr_result_if rsp_if ();

    lru_page_replacement_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if.sink),
        .rsp       (rsp_if.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lrupr_replacement_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .hits        (hits),
        .fills       (fills),
        .faults      (faults)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_lru_page_replacement_core: FAIL");
        $finish;
    end

    task automatic access_page(input logic [PAGE_BITS_DEF-1:0] pg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.page  <= pg;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_set_size(input logic [CFG_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [CFG_W-1:0]         phase_sizes [PHASES];
        logic [PAGE_BITS_DEF-1:0] pool [64];
        logic [PAGE_BITS_DEF-1:0] pg;
        int                       lim;
        int                       pool_n;

        phase_sizes  = '{6'd63, 6'd32, 6'd1, 6'd5, 6'd17, 6'd0, 6'd32, 6'd3, 6'd31, 6'd2,
                         6'd12};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_if.valid = 1'b0;
        req_if.page  = '0;
        cfg_writes   = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        access_page(16'h0000);
        access_page(16'hFFFF);
        access_page(16'h0000);
        access_page(16'h0000);
        access_page(16'hAAAA);
        access_page(16'h5555);
        access_page(16'h8000);
        access_page(16'h0001);
        // shrink below occupancy: deeper pages drop silently
        write_set_size(6'd2);
        access_page(16'h8000);
        access_page(16'h1234);
        access_page(16'h0001);
        write_set_size(6'd0);
        access_page(16'h0001);
        access_page(16'hFFFF);
        access_page(16'hFFFF);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_set_size(phase_sizes[ph]);
            lim = (phase_sizes[ph] == 0) ? 1 :
                  (phase_sizes[ph] > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(phase_sizes[ph]);
            pool_n = lim + $urandom_range(0, lim / 2 + 2);
            for (int j = 0; j < pool_n; j++)
                pool[j] = PAGE_BITS_DEF'($urandom_range(0, 16'hFFFF));
            no_idle = (ph % 4 == 2);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (n == PHASE_LEN / 2 && ph % 2 == 0)
                    drain();
                if ($urandom_range(0, 9) == 0)
                    pg = PAGE_BITS_DEF'($urandom_range(0, 16'hFFFF));
                else
                    pg = pool[$urandom_range(0, pool_n - 1)];
                access_page(pg);
            end
        end

        no_idle = 1'b0;
        req_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Covered %0d accesses: %0d hits, %0d fills, %0d faults with eviction.",
                 hits + fills + faults, hits, fills, faults);
        $display("Set size written %0d times, including 0, 1, 32 and 63, with shrinks.",
                 cfg_writes);
        if (mismatches == 0)
            $display("tb_lru_page_replacement_core: PASS");
        else
            $display("tb_lru_page_replacement_core: FAIL");
        $finish;
    end

endmodule
